// ===== hdl/ebpfd_pkg.sv =====
// Shared types and constants of the eBPF instruction stream decoder.
package ebpfd_pkg;

  localparam int CountBits = 16;
  localparam int CmpBits = (CountBits > 16) ? CountBits : 16;
  localparam logic [15:0] MaxInsnReset = 16'hFFFF;

  localparam int QDepth = 4;
  localparam int QPtrBits = $clog2(QDepth);

  typedef enum logic [1:0] {
    KindInsn       = 2'd0,
    KindEndOk      = 2'd1,
    KindEndTrunc   = 2'd2,
    KindEndTooMany = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              record_kind;
    logic [7:0]         opcode;
    logic [2:0]         insn_class;
    logic [3:0]         src_reg;
    logic [3:0]         dst_reg;
    logic signed [15:0] offset;
    logic signed [31:0] immediate;
    logic               is_wide;
    logic [31:0]        next_immediate;
    logic [3:0]         op_group;
    logic [1:0]         op_variant;
    logic [15:0]        decoded_count;
  } rec_t;

  // Records produced by one accepted byte: n is 0, 1 or 2; a goes out before b.
  typedef struct packed {
    logic [1:0] n;
    rec_t       a;
    rec_t       b;
  } push_t;

endpackage

// ===== hdl/ebpfd_byte_if.sv =====
// Byte stream channel: valid/ready with data byte and last-byte flag.
interface ebpfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

// ===== hdl/ebpfd_rec_if.sv =====
// Decoded record channel: valid/ready with the record fields.
interface ebpfd_rec_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record_kind;
  logic [7:0]         opcode;
  logic [2:0]         insn_class;
  logic [3:0]         src_reg;
  logic [3:0]         dst_reg;
  logic signed [15:0] offset;
  logic signed [31:0] immediate;
  logic               is_wide;
  logic [31:0]        next_immediate;
  logic [3:0]         op_group;
  logic [1:0]         op_variant;
  logic [15:0]        decoded_count;

  modport source(output valid, record_kind, opcode, insn_class, src_reg, dst_reg, offset,
                 immediate, is_wide, next_immediate, op_group, op_variant, decoded_count,
                 input ready);
  modport sink(input valid, record_kind, opcode, insn_class, src_reg, dst_reg, offset,
               immediate, is_wide, next_immediate, op_group, op_variant, decoded_count,
               output ready);
endinterface

// ===== hdl/ebpf_instruction_stream_decoder.sv =====
// Top level of the eBPF instruction stream decoder.
// Throughput: one byte per cycle while the output queue has room; each byte is framed
// in the cycle it is taken, and any record it completes is registered into the queue.
// A last byte that completes an instruction gives two records, drained one per cycle
// while rec_o is ready; byte_i stalls only when fewer than two of four slots are free.
// Reset: position, count, wide/discard flags and queue clear; max_instructions is 65535.
module ebpf_instruction_stream_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  ebpfd_byte_if.sink          byte_i,
  ebpfd_rec_if.source         rec_o
);
  import ebpfd_pkg::*;

  logic [15:0] max_insn_q;
  logic        accept;
  logic        room;
  push_t       push;
  rec_t        head;

  // Capacity register; the user must write it only while no transaction is in flight; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_insn_q <= MaxInsnReset;
    end else if (cfg_we_i) begin
      max_insn_q <= cfg_wdata_i;
    end
  end

  // Take a byte whenever the queue can absorb the worst case of two records.
  assign byte_i.ready = room;
  assign accept       = byte_i.valid && room;

  ebpfd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (byte_i.data_byte),
    .last_byte_i (byte_i.last_byte),
    .max_insn_i  (max_insn_q),
    .push_o      (push)
  );

  ebpfd_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (accept),
    .push_i    (push),
    .room_o    (room),
    .valid_o   (rec_o.valid),
    .head_o    (head),
    .pop_i     (rec_o.ready)
  );

  // Unpack the head record onto the output channel.
  assign rec_o.record_kind    = head.record_kind;
  assign rec_o.opcode         = head.opcode;
  assign rec_o.insn_class     = head.insn_class;
  assign rec_o.src_reg        = head.src_reg;
  assign rec_o.dst_reg        = head.dst_reg;
  assign rec_o.offset         = head.offset;
  assign rec_o.immediate      = head.immediate;
  assign rec_o.is_wide        = head.is_wide;
  assign rec_o.next_immediate = head.next_immediate;
  assign rec_o.op_group       = head.op_group;
  assign rec_o.op_variant     = head.op_variant;
  assign rec_o.decoded_count  = head.decoded_count;

endmodule

// ===== hdl/ebpfd_frame.sv =====
// Instruction framing: byte store, position, count, error state and record build.
module ebpfd_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic [15:0]          max_insn_i,
  output ebpfd_pkg::push_t     push_o
);
  import ebpfd_pkg::*;

  localparam logic [3:0] PosBasic = 4'd8;
  localparam logic [3:0] PosLastBasic = 4'd7;
  localparam logic [7:0] WideMask = 8'hE7;

  logic [7:0]           store_q [16];
  logic [3:0]           pos_q, pos_d, pos_inc;
  logic                 wide_q, wide_d;
  logic                 disc_q, disc_d;
  logic [CountBits-1:0] cnt_q, cnt_d, cnt_inc;
  logic                 too_many, tm_hit;
  logic                 emit_insn, insn_wide, emit_end;
  kind_e                end_kind;
  logic [7:0]           op, b7;
  rec_t                 insn_rec, end_rec;

  assign pos_inc  = pos_q + 4'd1;
  assign cnt_inc  = cnt_q + CountBits'(1);
  assign too_many = (CmpBits'(cnt_q) >= CmpBits'(max_insn_i)) || (cnt_q == '1);
  assign op       = store_q[0];

  always_comb begin
    pos_d     = pos_q;
    wide_d    = wide_q;
    disc_d    = disc_q;
    cnt_d     = cnt_q;
    tm_hit    = 1'b0;
    emit_insn = 1'b0;
    insn_wide = 1'b0;
    emit_end  = 1'b0;
    end_kind  = KindEndOk;
    if (accept_i) begin
      if (disc_q) begin
        if (last_byte_i) begin
          disc_d = 1'b0;
          pos_d  = '0;
          wide_d = 1'b0;
          cnt_d  = '0;
        end
      end else begin
        pos_d = pos_inc;
        if (!wide_q && pos_inc == PosBasic) begin
          if (too_many) begin
            tm_hit   = 1'b1;
            emit_end = 1'b1;
            end_kind = KindEndTooMany;
            disc_d   = 1'b1;
          end else if ((op & WideMask) == 8'h00) begin
            wide_d = 1'b1;
          end else begin
            pos_d     = '0;
            cnt_d     = cnt_inc;
            emit_insn = 1'b1;
          end
        end else if (wide_q && pos_inc == 4'd0) begin
          wide_d    = 1'b0;
          cnt_d     = cnt_inc;
          emit_insn = 1'b1;
          insn_wide = 1'b1;
        end
        if (last_byte_i) begin
          if (!tm_hit) begin
            emit_end = 1'b1;
            end_kind = (pos_d == 4'd0 && !wide_d) ? KindEndOk : KindEndTrunc;
          end
          // buffer done: drop all per-buffer state
          pos_d  = '0;
          wide_d = 1'b0;
          cnt_d  = '0;
          disc_d = 1'b0;
        end
      end
    end
  end

  // Byte seven is the incoming byte when a basic instruction completes.
  assign b7 = (pos_q == PosLastBasic) ? data_byte_i : store_q[7];

  always_comb begin
    insn_rec                = '0;
    insn_rec.record_kind    = KindInsn;
    insn_rec.opcode         = op;
    insn_rec.insn_class     = op[2:0];
    insn_rec.src_reg        = store_q[1][7:4];
    insn_rec.dst_reg        = store_q[1][3:0];
    insn_rec.offset         = {store_q[3], store_q[2]};
    insn_rec.immediate      = {b7, store_q[6], store_q[5], store_q[4]};
    insn_rec.is_wide        = insn_wide;
    insn_rec.next_immediate = insn_wide ?
                              {data_byte_i, store_q[14], store_q[13], store_q[12]} : 32'h0;
    if (op[2]) begin
      // ALU, JMP, JMP32, ALU64: operation and source bit
      insn_rec.op_group   = op[7:4];
      insn_rec.op_variant = {1'b0, op[3]};
    end else begin
      // load/store classes: mode and size
      insn_rec.op_group   = {1'b0, op[7:5]};
      insn_rec.op_variant = op[4:3];
    end
    insn_rec.decoded_count = 16'(cnt_inc);

    end_rec               = '0;
    end_rec.record_kind   = end_kind;
    end_rec.decoded_count = emit_insn ? 16'(cnt_inc) : 16'(cnt_q);
  end

  assign push_o.n = {emit_insn & emit_end, emit_insn ^ emit_end};
  assign push_o.a = emit_insn ? insn_rec : end_rec;
  assign push_o.b = end_rec;

  always_ff @(posedge clk_i) begin
    if (accept_i && !disc_q) begin
      store_q[pos_q] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      wide_q <= 1'b0;
      disc_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      wide_q <= wide_d;
      disc_q <= disc_d;
      cnt_q  <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && disc_q) |-> (push_o.n == 2'd0))
    else $error("record produced while discarding");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wide_q |-> pos_q[3])
    else $error("wide load pending outside its second half");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && tm_hit) |-> (push_o.n == 2'd1 && !emit_insn))
    else $error("too-many error produced more than the end record");

endmodule

// ===== hdl/ebpfd_outq.sv =====
// Output record queue taking up to two records per cycle while it has room for two, one out per transaction.
module ebpfd_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_en_i,
  input  ebpfd_pkg::push_t push_i,
  output logic             room_o,
  output logic             valid_o,
  output ebpfd_pkg::rec_t  head_o,
  input  logic             pop_i
);
  import ebpfd_pkg::*;

  rec_t                entry_q [QDepth];
  logic [QPtrBits-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_nx;
  logic [QPtrBits:0]   cnt_q, cnt_d;
  logic [1:0]          n_in;
  logic                pop;

  assign n_in    = push_en_i ? push_i.n : 2'd0;
  assign pop     = pop_i && valid_o;
  assign wptr_nx = wptr_q + QPtrBits'(1);
  assign wptr_d  = wptr_q + QPtrBits'(n_in);
  assign rptr_d  = rptr_q + QPtrBits'(pop);
  assign cnt_d   = cnt_q + (QPtrBits + 1)'(n_in) - (QPtrBits + 1)'(pop);

  assign room_o  = cnt_q <= (QPtrBits + 1)'(QDepth - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (n_in != 2'd0) begin
      entry_q[wptr_q] <= push_i.a;
    end
    if (n_in == 2'd2) begin
      entry_q[wptr_nx] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_in != 2'd0) |-> (cnt_q <= (QPtrBits + 1)'(QDepth - 2)))
    else $error("record pushed without room for two");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPtrBits + 1)'(QDepth))
    else $error("queue fill beyond depth");

endmodule

// ===== bench/tb_ebpf_instruction_stream_decoder.sv =====
// Self-checking testbench for the eBPF instruction stream decoder.
`timescale 1ns / 1ps

module tb_ebpf_instruction_stream_decoder;
  import ebpfd_pkg::*;

  localparam int HoldCycles = 300;     // long receiver hold-off to back up the block
  localparam int PhaseBytes = 200;     // accepted bytes per random phase
  localparam int SettleCycles = 4;     // settle time after the last expected record is taken

  // One input transaction; bit 8 of the packed form is the last-byte flag.
  typedef struct packed {
    logic       is_last;
    logic [7:0] data_b;
  } byte_item_t;

  // Track decoder state per accepted byte and compare records in order.
  class record_scoreboard;
    logic [7:0]  byte_store [16];
    logic [3:0]  byte_pos;
    logic        wide_pending;
    logic [15:0] insn_count;
    logic        discarding;
    logic [15:0] max_insns;
    rec_t        expected_records [$];
    int          mismatches;

    function new();
      foreach (byte_store[i]) byte_store[i] = '0;
      clear_buffer();
      max_insns = MaxInsnReset;
      mismatches = 0;
    endfunction

    function void clear_buffer();
      byte_pos = '0;
      wide_pending = 1'b0;
      insn_count = '0;
      discarding = 1'b0;
    endfunction

    function rec_t end_record(kind_e kind);
      rec_t r;
      r = '0;
      r.record_kind = kind;
      r.decoded_count = insn_count;
      return r;
    endfunction

    function rec_t insn_record(logic wide);
      rec_t r;
      logic [7:0] op;
      op = byte_store[0];
      r = '0;
      r.record_kind = KindInsn;
      r.opcode = op;
      r.insn_class = op[2:0];
      r.src_reg = byte_store[1][7:4];
      r.dst_reg = byte_store[1][3:0];
      r.offset = {byte_store[3], byte_store[2]};
      r.immediate = {byte_store[7], byte_store[6], byte_store[5], byte_store[4]};
      r.is_wide = wide;
      if (wide) begin
        r.next_immediate = {byte_store[15], byte_store[14], byte_store[13], byte_store[12]};
      end
      // ALU/JMP classes (4..7) carry op code and source bit, the rest mode and size
      if (op[2]) begin
        r.op_group = op[7:4];
        r.op_variant = {1'b0, op[3]};
      end else begin
        r.op_group = {1'b0, op[7:5]};
        r.op_variant = op[4:3];
      end
      r.decoded_count = insn_count;
      return r;
    endfunction

    // Returns 1 when the byte was taken into an instruction, 0 when dropped.
    function bit take_byte(logic [7:0] data_b, logic is_last);
      if (discarding) begin
        if (is_last) clear_buffer();
        return 1'b0;
      end
      byte_store[byte_pos] = data_b;
      byte_pos = byte_pos + 4'd1;
      if (!wide_pending && byte_pos == 4'd8) begin
        if (insn_count >= max_insns || insn_count == 16'hFFFF) begin
          expected_records.push_back(end_record(KindEndTooMany));
          if (is_last) clear_buffer();
          else discarding = 1'b1;
          return 1'b1;
        end
        if ((byte_store[0] & 8'hE7) == 8'h00) begin
          wide_pending = 1'b1;
        end else begin
          byte_pos = '0;
          insn_count = insn_count + 16'd1;
          expected_records.push_back(insn_record(1'b0));
        end
      end else if (wide_pending && byte_pos == 4'd0) begin
        wide_pending = 1'b0;
        insn_count = insn_count + 16'd1;
        expected_records.push_back(insn_record(1'b1));
      end
      if (is_last) begin
        if (byte_pos == 4'd0 && !wide_pending) begin
          expected_records.push_back(end_record(KindEndOk));
        end else begin
          expected_records.push_back(end_record(KindEndTrunc));
        end
        clear_buffer();
      end
      return 1'b1;
    endfunction

    function void report(string what, rec_t want, rec_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s", $realtime, what);
        $display("  exp kind=%0d op=%h cls=%0d src=%0d dst=%0d off=%0d",
                 want.record_kind, want.opcode, want.insn_class, want.src_reg,
                 want.dst_reg, want.offset);
        $display("      imm=%0d wide=%0d nimm=%h grp=%0d var=%0d cnt=%0d",
                 want.immediate, want.is_wide, want.next_immediate,
                 want.op_group, want.op_variant, want.decoded_count);
        $display("  got kind=%0d op=%h cls=%0d src=%0d dst=%0d off=%0d",
                 got.record_kind, got.opcode, got.insn_class, got.src_reg,
                 got.dst_reg, got.offset);
        $display("      imm=%0d wide=%0d nimm=%h grp=%0d var=%0d cnt=%0d",
                 got.immediate, got.is_wide, got.next_immediate,
                 got.op_group, got.op_variant, got.decoded_count);
      end
    endfunction

    function void check_record(rec_t got);
      rec_t want;
      if (expected_records.size() == 0) begin
        report("record with nothing expected", '0, got);
        return;
      end
      want = expected_records.pop_front();
      if (got !== want) report("record mismatch", want, got);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  ebpfd_byte_if byte_ch ();
  ebpfd_rec_if  rec_ch ();

  record_scoreboard sb = new();

  byte_item_t buf_q [$];      // buffer under construction
  byte_item_t carry_q [$];    // tail of a buffer that spans a register write
  bit         no_gaps = 1'b0;
  bit         hold_req = 1'b0;
  int         consumed = 0;

  ebpf_instruction_stream_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .byte_i     (byte_ch),
    .rec_o      (rec_ch)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte from a falling edge, hold it until the block takes it.
  task automatic send_item(byte_item_t it);
    int g;
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= it.data_b;
    byte_ch.last_byte <= it.is_last;
    do @(posedge clk_i); while (!byte_ch.ready);
    void'(sb.take_byte(it.data_b, it.is_last));
    consumed++;
    @(negedge clk_i);
    // Keep valid high into the next transaction unless a gap is drawn.
    if (!no_gaps) begin
      g = pick_gap();
      if (g > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end
  endtask

  // Build one buffer: mostly well-formed instruction runs, some random noise.
  task automatic build_buffer(int max_n);
    int n;
    int cut;
    logic [7:0] op;
    byte_item_t it;
    buf_q.delete();
    it.is_last = 1'b0;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 24)) begin
        it.data_b = 8'($urandom);
        buf_q.push_back(it);
      end
    end else begin
      n = $urandom_range(1, max_n);
      repeat (n) begin
        if ($urandom_range(0, 99) < 25) begin
          // Wide immediate load: LD class, IMM mode, any size bits.
          op = {3'b000, 2'($urandom_range(0, 3)), 3'b000};
          it.data_b = op;
          buf_q.push_back(it);
          repeat (15) begin
            it.data_b = 8'($urandom);
            buf_q.push_back(it);
          end
        end else begin
          op = 8'($urandom);
          if ((op & 8'hE7) == 8'h00) op[0] = 1'b1;
          it.data_b = op;
          buf_q.push_back(it);
          repeat (7) begin
            it.data_b = 8'($urandom);
            buf_q.push_back(it);
          end
        end
      end
      // Cut the tail off some buffers to end inside an instruction.
      if ($urandom_range(0, 99) < 20 && buf_q.size() > 1) begin
        cut = $urandom_range(1, buf_q.size() - 1);
        repeat (cut) void'(buf_q.pop_back());
      end
    end
    buf_q[buf_q.size() - 1].is_last = 1'b1;
  endtask

  // Stop offering and wait until every expected record has been taken.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (sb.expected_records.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_max(logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.max_insns = value;
    @(negedge clk_i);
  endtask

  // Run one register setting; optionally leave a buffer open across the next write.
  task automatic run_phase(logic [15:0] max_value, bit leave_open, bit hold);
    int start;
    int k;
    drain();
    write_max(max_value);
    // Start the long receiver hold-off while bytes keep coming.
    if (hold) hold_req = 1'b1;
    foreach (carry_q[i]) send_item(carry_q[i]);
    carry_q.delete();
    start = consumed;
    while (consumed - start < PhaseBytes) begin
      build_buffer((max_value < 16'd8) ? 3 : 6);
      no_gaps = ($urandom_range(0, 99) < 25);
      foreach (buf_q[i]) send_item(buf_q[i]);
    end
    no_gaps = 1'b0;
    if (leave_open && $urandom_range(0, 1) == 1) begin
      build_buffer(4);
      if (buf_q.size() > 1) begin
        k = $urandom_range(1, buf_q.size() - 1);
        for (int i = 0; i < buf_q.size(); i++) begin
          if (i < k) send_item(buf_q[i]);
          else carry_q.push_back(buf_q[i]);
        end
      end
    end
  endtask

  // Check every record that crosses the output handshake.
  always @(posedge clk_i) begin : rec_monitor
    rec_t got;
    if (rst_ni && rec_ch.valid && rec_ch.ready) begin
      got.record_kind    = kind_e'(rec_ch.record_kind);
      got.opcode         = rec_ch.opcode;
      got.insn_class     = rec_ch.insn_class;
      got.src_reg        = rec_ch.src_reg;
      got.dst_reg        = rec_ch.dst_reg;
      got.offset         = rec_ch.offset;
      got.immediate      = rec_ch.immediate;
      got.is_wide        = rec_ch.is_wide;
      got.next_immediate = rec_ch.next_immediate;
      got.op_group       = rec_ch.op_group;
      got.op_variant     = rec_ch.op_variant;
      got.decoded_count  = rec_ch.decoded_count;
      sb.check_record(got);
    end
  end

  // Receiver: random stalls and runs, plus one long hold-off on request.
  initial begin : rec_ready_driver
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    rec_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // Hold off long enough for the output queue to fill and stall the input.
        rec_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          stall_left = pick_gap();
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
        end
        if (stall_left > 0) begin
          rec_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          rec_ch.ready <= 1'b1;
          run_left--;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    // Bit 8 marks the last byte of a buffer.
    logic [8:0] directed [19];
    logic [15:0] phase_max [6];
    directed = '{
      // Extremes: ALU64 opcode 0xFF, all-ones registers, minimum offset and immediate,
      // last byte on a boundary gives an instruction and an end ok record.
      9'h0FF, 9'h0FF, 9'h000, 9'h080, 9'h000, 9'h000, 9'h000, 9'h180,
      // A single byte buffer ends truncated.
      9'h100,
      // Memory-class load with maximum offset and immediate, then two trailing bytes.
      9'h061, 9'h012, 9'h0FF, 9'h07F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,
      9'h003, 9'h104
    };
    phase_max = '{16'hFFFF, 16'd0, 16'd1, 16'd3, 16'd2, 16'hFFFF};
    phase_max[4] = 16'($urandom_range(2, 8));

    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;

    // Hold reset, then release it on a falling edge.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_item(byte_item_t'(directed[i]));

    // The first phase carries the long receiver hold-off.
    foreach (phase_max[p]) run_phase(phase_max[p], p != 5, p == 0);

    // Wait for the last records, then let the block settle before the summary.
    byte_ch.valid <= 1'b0;
    while (sb.expected_records.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
